[src/frame_time_smoother_fixed_step_defines.svh]
// ----------------------------------------------------------------------------
// Frame time smoother assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef FRAME_TIME_SMOOTHER_FIXED_STEP_DEFINES_SVH
`define FRAME_TIME_SMOOTHER_FIXED_STEP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FTS_ASSERT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("fts assertion failed");
`define FTS_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("fts assertion failed");
`else
`define FTS_ASSERT(label, ck, rn, ante, cons)
`define FTS_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif

`endif

[src/fts_pkg.sv]
// ----------------------------------------------------------------------------
// Frame time smoother package
// Field widths, limits, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package fts_pkg;

  localparam int TIME_W      = 32;
  localparam int PERIOD_IN_W = 24;
  localparam int PERIOD_W    = 16;
  localparam int STEPS_W     = 8;
  localparam int LERP_W      = 16;
  localparam int ACC_W       = 17;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 80;

  localparam logic [PERIOD_W-1:0]  PERIOD_MAX     = 16'd51200;
  localparam logic [PERIOD_W-1:0]  STEP_MIN       = 16'd256;
  localparam logic [PERIOD_W-1:0]  FIXED_STEP_RST = 16'd4267;
  localparam logic [TIME_W-1:0]    FRAME_DELTA_MAX = 32'd200;
  localparam logic [STEPS_W-1:0]   STEPS_MAX      = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_MODE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_STEP = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_AVG,
    ST_STEPS,
    ST_LERP,
    ST_DONE
  } fts_state_t;

endpackage

`default_nettype wire

[src/fts_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/fts_div.sv]
// ----------------------------------------------------------------------------
// Frame time smoother divider
// Restoring divider, one quotient bit per cycle, with a preset remainder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_time_smoother_fixed_step_defines.svh"

module fts_div import fts_pkg::*; #(
  parameter int DIVD_W = 20,
  parameter int NB_W   = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DIVD_W-1:0]   dividend,
  input  wire logic [PERIOD_W-1:0] divisor,
  input  wire logic [PERIOD_W-1:0] rem_init,
  input  wire logic [NB_W-1:0]     nbits,
  output logic                     done,
  output logic      [DIVD_W-1:0]   quot,
  output logic      [PERIOD_W-1:0] rem
);

  logic                busy_r;
  logic                done_r;
  logic [NB_W-1:0]     cnt_r;
  logic [DIVD_W-1:0]   dvd_r;
  logic [DIVD_W-1:0]   quot_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [PERIOD_W-1:0] dsr_r;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W:0]   diff;
  logic                ge;

  assign trial = {rem_r, dvd_r[DIVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == NB_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= dividend;
      dsr_r  <= divisor;
      rem_r  <= rem_init;
      quot_r <= '0;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[DIVD_W-2:0], 1'b0};
      quot_r <= {quot_r[DIVD_W-2:0], ge};
      rem_r  <= ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

  `FTS_ASSERT(a_start_idle, clk, rst_n, start, !busy_r)
  `FTS_ASSERT(a_done_not_busy, clk, rst_n, done_r, !busy_r)
  `FTS_ASSERT(a_rem_below, clk, rst_n, busy_r, rem_r < dsr_r)

endmodule

`default_nettype wire

[src/frame_time_smoother_fixed_step.sv]
// ----------------------------------------------------------------------------
// Frame time smoother with fixed step accumulator
// Windowed frame period average, spike and pause filtering, step counting.
// ----------------------------------------------------------------------------
// One input item per frame on the in_ channel: wall time and reported period
// in in_tdata, the restart flag in in_tuser. A restart item clears the window
// and accumulator, re-bases the clock and gives no result. Every other item
// gives one result item on the out_ channel.
// Configuration writes on the cfg_ channel are taken in any cycle and must
// only be issued while no item is in flight.
// The window lives in a one-port-read, one-port-write RAM; the running sum,
// fill count and head pointer sit in registers. A shared one-bit-per-cycle
// divider forms the average, the step count and the lerp fraction.
// An item passes through the push and average states and, in fixed mode, the
// step and lerp divides before the result state. One item at a time; in_tready
// rises again together with out_tvalid when the result is loaded. A restart
// item is taken without leaving the idle state.
// The result sits in an output register, so a stalled receiver does not stop
// the next item from being accepted; only a second result waits for it.
// Reset (rst_n low, synchronous) empties the window, zeroes the clock base
// and accumulator, and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_time_smoother_fixed_step_defines.svh"

module frame_time_smoother_fixed_step import fts_pkg::*; #(
  parameter int WINDOW = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // [31:0] wall_time, [55:32] frame_period
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] restart
  input  wire logic                   in_tuser,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [15:0] logic_time, [23:16] step_count, [39:24] lerp_factor,
  // [40] suspended, [72:41] suspended_ms, [79:73] zero
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int HIST_AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W   = $clog2(WINDOW + 1);
  localparam int SUM_W   = PERIOD_W + $clog2(WINDOW);
  localparam int DIVD_W  = (SUM_W > ACC_W) ? SUM_W : ACC_W;
  localparam int NB_W    = $clog2(DIVD_W + 1);

  fts_state_t state_r, state_nxt;

  logic                   step_mode_r;
  logic [PERIOD_W-1:0]    fixed_step_r;
  logic [TIME_W-1:0]      prev_time_r;
  logic [TIME_W-1:0]      delta_r;
  logic [PERIOD_W-1:0]    val_r;
  logic [CNT_W-1:0]       hist_cnt_r;
  logic [HIST_AW-1:0]     head_r;
  logic [SUM_W-1:0]       sum_r;
  logic [ACC_W-1:0]       acc_r;
  logic [PERIOD_W-1:0]    res_logic_r;
  logic [STEPS_W-1:0]     res_steps_r;
  logic [LERP_W-1:0]      res_lerp_r;
  logic                   res_susp_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tvalid_r;

  logic                   in_accept;
  logic                   in_restart;
  logic [TIME_W-1:0]      in_wall;
  logic [PERIOD_IN_W-1:0] in_period;
  logic [TIME_W-1:0]      delta_c;
  logic [PERIOD_W-1:0]    frame_c;
  logic [PERIOD_W-1:0]    period_c;
  logic [PERIOD_W-1:0]    step_eff;

  logic [PERIOD_W-1:0]    rd_data;
  logic                   ram_we;
  logic                   hist_full;
  logic [SUM_W-1:0]       sum_nxt;
  logic [CNT_W-1:0]       cnt_nxt;

  logic                   div_start;
  logic [DIVD_W-1:0]      div_dividend;
  logic [PERIOD_W-1:0]    div_divisor;
  logic [PERIOD_W-1:0]    div_rem_init;
  logic [NB_W-1:0]        div_nbits;
  logic                   div_done;
  logic [DIVD_W-1:0]      div_quot;
  logic [PERIOD_W-1:0]    div_rem;

  logic [PERIOD_W-1:0]    avg;
  logic [PERIOD_W+1:0]    avg3;
  logic [PERIOD_W-1:0]    logic_v;
  logic                   susp_v;
  logic                   susp_f;
  logic [PERIOD_W-1:0]    frame_f;
  logic [ACC_W-1:0]       acc_sum;
  logic                   out_load;

  // delta * 256 > 10 * x, with a negative delta never a pause
  function automatic logic pause_hit(input logic [TIME_W-1:0] d,
                                     input logic [PERIOD_W-1:0] x);
    logic [TIME_W+7:0]   d256;
    logic [PERIOD_W+3:0] x10;
    d256 = {d, 8'h00};
    x10  = {x, 3'b000} + {3'b000, x, 1'b0};
    return !d[TIME_W-1] && (d256 > (TIME_W + 8)'(x10));
  endfunction

  assign in_accept  = in_tvalid && in_tready;
  assign in_wall    = in_tdata[TIME_W-1:0];
  assign in_period  = in_tdata[TIME_W+PERIOD_IN_W-1:TIME_W];
  assign in_restart = in_tuser;
  assign cfg_ready  = 1'b1;

  assign delta_c = in_wall - prev_time_r;

  always_comb begin
    if (delta_c[TIME_W-1] || (delta_c == '0)) begin
      frame_c = '0;
    end else if (delta_c >= FRAME_DELTA_MAX) begin
      frame_c = PERIOD_MAX;
    end else begin
      frame_c = {delta_c[7:0], 8'h00};
    end
  end

  assign period_c = (in_period > PERIOD_IN_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                          : in_period[PERIOD_W-1:0];

  assign step_eff = (fixed_step_r < STEP_MIN)   ? STEP_MIN :
                    (fixed_step_r > PERIOD_MAX) ? PERIOD_MAX : fixed_step_r;

  assign hist_full = hist_cnt_r == CNT_W'(WINDOW);
  assign sum_nxt   = sum_r - (hist_full ? SUM_W'(rd_data) : '0) + SUM_W'(val_r);
  assign cnt_nxt   = hist_full ? hist_cnt_r : hist_cnt_r + 1'b1;

  assign avg     = div_quot[PERIOD_W-1:0];
  assign avg3    = {1'b0, avg, 1'b0} + {2'b00, avg};
  assign logic_v = ({2'b00, val_r} > avg3) ? avg : val_r;
  assign susp_v  = pause_hit(delta_r, logic_v);
  assign susp_f  = pause_hit(delta_r, avg);
  assign frame_f = susp_f ? avg : val_r;
  assign acc_sum = acc_r + ACC_W'(frame_f);

  assign out_load = !out_tvalid_r || out_tready;

  fts_ram #(
    .WIDTH (PERIOD_W),
    .DEPTH (WINDOW),
    .AW    (HIST_AW)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_r),
    .wdata (val_r),
    .re    (in_accept),
    .raddr (head_r),
    .rdata (rd_data)
  );

  fts_div #(
    .DIVD_W (DIVD_W),
    .NB_W   (NB_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .rem_init (div_rem_init),
    .nbits    (div_nbits),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept && !in_restart) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        state_nxt = ST_AVG;
      end
      ST_AVG: begin
        if (div_done) begin
          state_nxt = step_mode_r ? ST_STEPS : ST_DONE;
        end
      end
      ST_STEPS: begin
        if (div_done) begin
          state_nxt = ST_LERP;
        end
      end
      ST_LERP: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    ram_we       = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = step_eff;
    div_rem_init = '0;
    div_nbits    = NB_W'(DIVD_W);
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_PUSH: begin
        ram_we       = 1'b1;
        div_start    = 1'b1;
        div_dividend = DIVD_W'(sum_nxt);
        div_divisor  = PERIOD_W'(cnt_nxt);
      end
      ST_AVG: begin
        div_start    = div_done && step_mode_r;
        div_dividend = DIVD_W'(acc_sum);
      end
      ST_STEPS: begin
        div_start    = div_done;
        div_rem_init = div_rem;
        div_nbits    = NB_W'(LERP_W);
      end
      ST_LERP, ST_DONE: begin
        div_start = 1'b0;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      step_mode_r  <= 1'b0;
      fixed_step_r <= FIXED_STEP_RST;
      prev_time_r  <= '0;
      hist_cnt_r   <= '0;
      head_r       <= '0;
      sum_r        <= '0;
      acc_r        <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_STEP_MODE) begin
          step_mode_r <= cfg_data[0];
        end else if (cfg_index == REG_FIXED_STEP) begin
          fixed_step_r <= cfg_data;
        end
      end

      if (in_accept) begin
        prev_time_r <= in_wall;
        if (in_restart) begin
          hist_cnt_r <= '0;
          head_r     <= '0;
          sum_r      <= '0;
          acc_r      <= '0;
        end
      end

      if (state_r == ST_PUSH) begin
        sum_r      <= sum_nxt;
        hist_cnt_r <= cnt_nxt;
        head_r     <= (head_r == HIST_AW'(WINDOW - 1)) ? '0 : head_r + 1'b1;
      end

      if ((state_r == ST_AVG) && div_done && step_mode_r) begin
        acc_r <= acc_sum;
      end
      if ((state_r == ST_STEPS) && div_done) begin
        acc_r <= ACC_W'(div_rem);
      end

      if ((state_r == ST_DONE) && out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      delta_r <= delta_c;
      val_r   <= step_mode_r ? frame_c : period_c;
    end

    if ((state_r == ST_AVG) && div_done) begin
      if (step_mode_r) begin
        res_logic_r <= step_eff;
        res_susp_r  <= susp_f;
      end else begin
        res_logic_r <= logic_v;
        res_susp_r  <= susp_v;
        res_steps_r <= '0;
        res_lerp_r  <= '0;
      end
    end

    if ((state_r == ST_STEPS) && div_done) begin
      res_steps_r <= (div_quot > DIVD_W'(STEPS_MAX)) ? STEPS_MAX : div_quot[STEPS_W-1:0];
    end

    if ((state_r == ST_LERP) && div_done) begin
      res_lerp_r <= div_quot[LERP_W-1:0];
    end

    if ((state_r == ST_DONE) && out_load) begin
      out_tdata_r <= {7'b0000000,
                      (res_susp_r ? delta_r : '0),
                      res_susp_r,
                      res_lerp_r,
                      res_steps_r,
                      res_logic_r};
    end
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  `FTS_ASSERT(a_cnt_bound, clk, rst_n, 1'b1, hist_cnt_r <= CNT_W'(WINDOW))
  `FTS_ASSERT_NEXT(a_restart_clear, clk, rst_n, in_accept && in_restart, hist_cnt_r == '0 && sum_r == '0 && acc_r == '0)
  `FTS_ASSERT(a_acc_below_step, clk, rst_n, state_r == ST_LERP, acc_r < ACC_W'(step_eff))

endmodule

`default_nettype wire

[tb/sv/frame_time_smoother_fixed_step_tb.sv]
// ----------------------------------------------------------------------------
// Frame time smoother testbench
// Drives frame items into the smoother in variable and fixed step modes and
// checks every result against an in-bench window, clamp and step predictor,
// with random source gaps, sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module frame_time_smoother_fixed_step_tb;
  import fts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW        = 16;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASE_ITEMS   = 285;

  typedef struct packed {
    logic [31:0] susp_ms;
    logic        susp;
    logic [15:0] lerp;
    logic [7:0]  steps;
    logic [15:0] logic_time;
  } frame_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor state
  logic        mode_fixed = 1'b0;
  logic [15:0] step_len = FIXED_STEP_RST;
  logic [15:0] win_mem [WINDOW];
  int unsigned win_fill = 0;
  int unsigned win_head = 0;
  int unsigned win_sum = 0;
  logic [31:0] prev_wall = '0;
  int unsigned step_acc = 0;

  frame_result_t pending_frames[$];

  int          mismatches = 0;
  int          frames_checked = 0;
  int          restarts_sent = 0;
  int          pauses_seen = 0;
  bit          src_gaps = 1'b0;
  bit          sink_stalls = 1'b0;
  int unsigned sink_hold = 0;
  logic [31:0] wall_ms = '0;

  always #6 clk = ~clk;

  frame_time_smoother_fixed_step #(
    .WINDOW(WINDOW)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic int unsigned window_push(input int unsigned v);
    if (win_fill < WINDOW) begin
      win_fill++;
    end else begin
      win_sum -= 32'(win_mem[win_head]);
    end
    win_mem[win_head] = v[15:0];
    win_sum += v;
    win_head = (win_head + 1) % WINDOW;
    return win_sum / win_fill;
  endfunction

  function automatic bit smooth_frame(input logic [31:0] wall, input logic [23:0] period_in,
                                      input logic restart, output frame_result_t r);
    logic signed [31:0] delta;
    longint             d;
    int unsigned        period, avg, frame, step, n;
    r = '0;
    if (restart) begin
      win_fill = 0;
      win_head = 0;
      win_sum = 0;
      step_acc = 0;
      prev_wall = wall;
      return 1'b0;
    end
    delta = wall - prev_wall;
    d = longint'(delta);
    prev_wall = wall;
    if (!mode_fixed) begin
      period = (period_in > 24'(PERIOD_MAX)) ? 32'(PERIOD_MAX) : 32'(period_in);
      avg = window_push(period);
      if (period > 3 * avg) period = avg;
      r.logic_time = period[15:0];
      if (d * 256 > 10 * longint'(period)) begin
        r.susp = 1'b1;
        r.susp_ms = delta;
      end
    end else begin
      step = 32'(step_len);
      if (step < 32'(STEP_MIN)) step = 32'(STEP_MIN);
      if (step > 32'(PERIOD_MAX)) step = 32'(PERIOD_MAX);
      if (d <= 0) frame = 0;
      else if (d >= 200) frame = 32'(PERIOD_MAX);
      else frame = 32'(d * 256);
      avg = window_push(frame);
      if (d * 256 > 10 * longint'(avg)) begin
        frame = avg;
        r.susp = 1'b1;
        r.susp_ms = delta;
      end
      step_acc += frame;
      n = step_acc / step;
      step_acc = step_acc % step;
      r.steps = (n > 255) ? STEPS_MAX : n[7:0];
      r.lerp = 16'((step_acc << 16) / step);
      r.logic_time = step[15:0];
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      if (cfg_index == REG_STEP_MODE) mode_fixed <= cfg_data[0];
      else if (cfg_index == REG_FIXED_STEP) step_len <= cfg_data;
    end
  end

  always @(posedge clk) begin : frame_capture
    frame_result_t r;
    if (rst_n && in_tvalid && in_tready) begin
      if (smooth_frame(in_tdata[31:0], in_tdata[55:32], in_tuser, r)) begin
        pending_frames.insert(pending_frames.size(), r);
      end else begin
        restarts_sent++;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    frame_result_t want, got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[72:0];
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        check_field("logic_time", 32'(want.logic_time), 32'(got.logic_time));
        check_field("step_count", 32'(want.steps), 32'(got.steps));
        check_field("lerp_factor", 32'(want.lerp), 32'(got.lerp));
        check_field("suspended", 32'(want.susp), 32'(got.susp));
        check_field("suspended_ms", want.susp_ms, got.susp_ms);
        check_field("pad", 32'd0, 32'(out_tdata[79:73]));
        frames_checked++;
        if (want.susp) pauses_seen++;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        stall = sink_hold;
        sink_hold = 0;
      end else begin
        stall = sink_stalls ? pick_gap() : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_frame(input logic [31:0] wall, input logic [23:0] period,
                            input logic restart);
    int unsigned gap;
    gap = src_gaps ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= {period, wall};
    in_tuser <= restart;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] mode_word, input logic [15:0] step);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_STEP_MODE, mode_word);
    write_reg(REG_FIXED_STEP, step);
  endtask

  task automatic test_variable_edges();
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    send_frame(32'd0, 24'd0, 1'b1);
    send_frame(32'd16, 24'd4096, 1'b0);
    send_frame(32'd33, 24'd0, 1'b0);
    send_frame(32'd50, 24'd51200, 1'b0);
    send_frame(32'd66, 24'd51201, 1'b0);
    send_frame(32'd83, 24'hFFFFFF, 1'b0);
    send_frame(32'd100, 24'd4352, 1'b0);
    send_frame(32'd90, 24'd4096, 1'b0);
    send_frame(32'h7FFFFFFF, 24'd4096, 1'b0);
    send_frame(32'h80000000, 24'd4096, 1'b0);
    send_frame(32'h00000000, 24'd4096, 1'b0);
    send_frame(32'hFFFFFFFF, 24'd4096, 1'b1);
    send_frame(32'd5, 24'd4267, 1'b0);
  endtask

  task automatic test_fixed_edges();
    set_config(16'hFFFF, 16'h0000);
    write_reg(8'hFF, 16'h1234);
    write_reg(8'd2, 16'h0000);
    send_frame(32'd1000, 24'hABCDEF, 1'b1);
    send_frame(32'd1000, 24'd0, 1'b0);
    send_frame(32'd1001, 24'd0, 1'b0);
    send_frame(32'd1200, 24'd0, 1'b0);
    send_frame(32'd1400, 24'd0, 1'b0);
    send_frame(32'd1300, 24'd0, 1'b0);
    send_frame(32'd101300, 24'd0, 1'b0);
    set_config(16'h0001, 16'hFFFF);
    send_frame(32'd101316, 24'd0, 1'b0);
    send_frame(32'd101516, 24'd0, 1'b0);
    set_config(16'h0001, 16'd255);
    send_frame(32'd101533, 24'd0, 1'b0);
    set_config(16'h0001, 16'd51201);
    send_frame(32'd101549, 24'd0, 1'b0);
  endtask

  task automatic test_sink_hold_off();
    drain_results();
    src_gaps = 1'b0;
    sink_hold = HOLD_CYCLES;
    for (int i = 0; i < 6; i++) begin
      wall_ms += 17;
      send_frame(wall_ms, 24'd4352, 1'b0);
    end
    drain_results();
  endtask

  task automatic random_frame();
    int unsigned        r, dt;
    logic        [23:0] period;
    logic               restart;
    r = $urandom_range(0, 99);
    restart = 1'b0;
    dt = $urandom_range(10, 40);
    period = 24'(dt * 256 + $urandom_range(0, 255));
    if (r < 2) begin
      restart = 1'b1;
    end else if (r < 80) begin
    end else if (r < 88) begin
      dt = $urandom_range(40, 250);
      period = $urandom_range(0, 1) ? 24'(dt * 256) : 24'($urandom_range(0, 4096));
    end else if (r < 93) begin
      period = 24'($urandom_range(51200, 24'hFFFFFF));
    end else if (r < 96) begin
      dt = $urandom_range(300, 100000);
    end else if (r < 98) begin
      dt = -$urandom_range(1, 50);
    end else begin
      dt = $urandom();
      period = 24'($urandom());
    end
    wall_ms += dt;
    send_frame(wall_ms, period, restart);
  endtask

  task automatic test_random_modes();
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_config(16'h0000, FIXED_STEP_RST);
        1: set_config(16'h0001, FIXED_STEP_RST);
        2: set_config(16'h0001, STEP_MIN);
        3: set_config(16'h0001, PERIOD_MAX);
        4: set_config(16'h0001, 16'($urandom_range(256, 51200)));
        5: set_config(16'h0001, 16'($urandom_range(0, 65535)));
        default: set_config(16'($urandom() & 32'hFFFE), 16'($urandom()));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 100 == 0) begin
          src_gaps = ($urandom_range(0, 3) != 0);
          sink_stalls = ($urandom_range(0, 3) != 0);
        end
        if (i == PHASE_ITEMS / 2) drain_results();
        random_frame();
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_variable_edges();
    test_fixed_edges();
    test_sink_hold_off();
    test_random_modes();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results (%0d flagged as pauses), %0d restarts,",
             frames_checked, pauses_seen, restarts_sent);
    $display("in variable and fixed step modes with clamped and random step lengths.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_frames.size());
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/fts_pkg.sv
src/fts_ram.sv
src/fts_div.sv
src/frame_time_smoother_fixed_step.sv
tb/sv/frame_time_smoother_fixed_step_tb.sv
